[design/ywc_pkg.sv]
// ----------------------------------------------------------------------------
// YUV420 window compositor package
// Shared constants, register codes and item types for the compositor blocks.
// ----------------------------------------------------------------------------
package ywc_pkg;

  // Fixed field widths.
  localparam int REG_W       = 13;
  localparam int WIN_POS_W   = 12;
  localparam int PIXEL_W     = 8;
  localparam int CFG_INDEX_W = 3;

  // Defaults for the top-level parameters.
  localparam int MAX_DIM_DEF    = 4096;
  localparam int ADDR_BITS_DEF  = 25;
  localparam int ALIGN_STEP_DEF = 4;

  // Depth of the queue between the classifier and the address pipeline.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_WIN_X      = 3'd4,
    CFG_WIN_Y      = 3'd5,
    CFG_WIN_W      = 3'd6,
    CFG_WIN_H      = 3'd7
  } cfg_index_t;

  // Plane codes.
  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // Classification of one byte, handed from the front to the back.
  typedef struct packed {
    plane_t plane;
    logic   write_en;
    logic   out_of_frame;
    logic   frame_end;
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

endpackage

[design/ywc_queue.sv]
// ----------------------------------------------------------------------------
// YUV420 window compositor queue
// Small first-in first-out buffer that decouples the front and back parts.
// ----------------------------------------------------------------------------
module ywc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[design/ywc_front.sv]
// ----------------------------------------------------------------------------
// YUV420 window compositor front
// Tracks plane, row and column of each source byte and classifies it against
// the copy area and the destination plane.
// ----------------------------------------------------------------------------
module ywc_front
  import ywc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int DIM_W  = $clog2(MAX_DIM + 1),
  localparam int CNT_W  = $clog2(MAX_DIM),
  localparam int CMP_W  = ((CNT_W > WIN_POS_W) ? CNT_W : WIN_POS_W) + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 frame_start,
  input  logic [DIM_W-1:0]     src_w,
  input  logic [DIM_W-1:0]     src_h,
  input  logic [DIM_W-1:0]     dst_w,
  input  logic [DIM_W-1:0]     dst_h,
  input  logic [WIN_POS_W-1:0] win_x,
  input  logic [WIN_POS_W-1:0] win_y,
  input  logic [REG_W-1:0]     win_w,
  input  logic [REG_W-1:0]     win_h,
  output item_flags_t          flags,
  output logic [CMP_W-1:0]     tgt_x,
  output logic [CMP_W-1:0]     tgt_y,
  output logic [DIM_W-1:0]     lim_w
);

  // Position registers.
  plane_t           plane_index;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;

  plane_t           plane_index_next;
  logic [CNT_W-1:0] row_count_next;
  logic [CNT_W-1:0] col_count_next;

  plane_t               plane;
  logic [CNT_W-1:0]     row;
  logic [CNT_W-1:0]     col;
  logic [CMP_W-1:0]     cw;
  logic [CMP_W-1:0]     ch;
  logic [CMP_W-1:0]     pw;
  logic [CMP_W-1:0]     ph;
  logic [CMP_W-1:0]     copy_w;
  logic [CMP_W-1:0]     copy_h;
  logic [WIN_POS_W-1:0] ox;
  logic [WIN_POS_W-1:0] oy;
  logic [DIM_W-1:0]     lim_h;
  logic                 in_copy;
  logic                 in_frame;
  logic                 col_last;
  logic                 row_last;

  // Copy area is the source size clipped to the window size.
  always_comb begin
    cw = (CMP_W'(win_w) < CMP_W'(src_w)) ? CMP_W'(win_w) : CMP_W'(src_w);
    ch = (CMP_W'(win_h) < CMP_W'(src_h)) ? CMP_W'(win_h) : CMP_W'(src_h);
  end

  // Frame start forces the first luma position.
  always_comb begin
    plane = frame_start ? PLANE_Y : plane_index;
    row   = frame_start ? '0 : row_count;
    col   = frame_start ? '0 : col_count;
  end

  // Per-plane geometry: chroma planes use half of every dimension.
  always_comb begin
    if (plane == PLANE_Y) begin
      pw     = CMP_W'(src_w);
      ph     = CMP_W'(src_h);
      copy_w = cw;
      copy_h = ch;
      ox     = win_x;
      oy     = win_y;
      lim_w  = dst_w;
      lim_h  = dst_h;
    end else begin
      pw     = CMP_W'(src_w >> 1);
      ph     = CMP_W'(src_h >> 1);
      copy_w = cw >> 1;
      copy_h = ch >> 1;
      ox     = win_x >> 1;
      oy     = win_y >> 1;
      lim_w  = dst_w >> 1;
      lim_h  = dst_h >> 1;
    end
  end

  // Target position and classification.
  always_comb begin
    tgt_x    = CMP_W'(ox) + CMP_W'(col);
    tgt_y    = CMP_W'(oy) + CMP_W'(row);
    in_copy  = (CMP_W'(col) < copy_w) && (CMP_W'(row) < copy_h);
    in_frame = (tgt_x < CMP_W'(lim_w)) && (tgt_y < CMP_W'(lim_h));
    col_last = (CMP_W'(col) + CMP_W'(1)) >= pw;
    row_last = (CMP_W'(row) + CMP_W'(1)) >= ph;

    flags.plane        = plane;
    flags.write_en     = in_copy && in_frame;
    flags.out_of_frame = in_copy && !in_frame;
    flags.frame_end    = col_last && row_last && (plane == PLANE_V);
  end

  // Advance column, then row, then plane; wrap after the last V byte.
  always_comb begin
    plane_index_next = plane;
    row_count_next   = row;
    col_count_next   = col + CNT_W'(1);
    if (col_last) begin
      col_count_next = '0;
      row_count_next = row + CNT_W'(1);
      if (row_last) begin
        row_count_next = '0;
        unique case (plane)
          PLANE_Y: plane_index_next = PLANE_U;
          PLANE_U: plane_index_next = PLANE_V;
          PLANE_V: plane_index_next = PLANE_Y;
          default: plane_index_next = PLANE_Y;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_index <= PLANE_Y;
      row_count   <= '0;
      col_count   <= '0;
    end else if (accept) begin
      plane_index <= plane_index_next;
      row_count   <= row_count_next;
      col_count   <= col_count_next;
    end
  end

endmodule

[design/ywc_back.sv]
// ----------------------------------------------------------------------------
// YUV420 window compositor back
// Two-stage address pipeline: row offset product, then plane base and column
// are added into the destination byte address held in the output register.
// ----------------------------------------------------------------------------
module ywc_back
  import ywc_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int DIM_W    = $clog2(MAX_DIM + 1),
  localparam int CNT_W    = $clog2(MAX_DIM),
  localparam int CMP_W    = ((CNT_W > WIN_POS_W) ? CNT_W : WIN_POS_W) + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DIM_W-1:0]     dst_w,
  input  logic [DIM_W-1:0]     dst_h,
  input  logic                 in_valid,
  output logic                 in_pop,
  input  item_flags_t          in_flags,
  input  logic [PIXEL_W-1:0]   in_pixel,
  input  logic [CMP_W-1:0]     in_tgt_x,
  input  logic [CMP_W-1:0]     in_tgt_y,
  input  logic [DIM_W-1:0]     in_lim_w,
  output logic                 out_valid,
  input  logic                 out_ready,
  output item_flags_t          out_flags,
  output logic [PIXEL_W-1:0]   out_pixel,
  output logic [ADDR_BITS-1:0] out_addr
);

  localparam int BASE_W = 2 * DIM_W + 1;
  localparam int PROD_W = CMP_W + DIM_W;
  localparam int WIDE_W = PROD_W + 2;
  localparam int SUM_W  = (ADDR_BITS > WIDE_W) ? ADDR_BITS : WIDE_W;

  // Plane bases follow the configuration: U after Y, V after a quarter more.
  logic [BASE_W-1:0] base_u;
  logic [BASE_W-1:0] base_v;

  logic               b1_valid;
  item_flags_t        b1_flags;
  logic [PIXEL_W-1:0] b1_pixel;
  logic [PROD_W-1:0]  b1_prod;
  logic [CMP_W-1:0]   b1_tgt_x;

  logic              b1_ready;
  logic              b2_ready;
  logic [BASE_W-1:0] base_sel;
  logic [SUM_W-1:0]  addr_sum;

  always_ff @(posedge clk) begin
    base_u <= BASE_W'(dst_w) * BASE_W'(dst_h);
    base_v <= base_u + (base_u >> 2);
  end

  // Handshake between the stages.
  assign b2_ready = !out_valid || out_ready;
  assign b1_ready = !b1_valid || b2_ready;
  assign in_pop   = in_valid && b1_ready;

  // First stage: row offset inside the destination plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_ready) begin
      b1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      b1_flags <= in_flags;
      b1_pixel <= in_pixel;
      b1_prod  <= PROD_W'(in_tgt_y) * PROD_W'(in_lim_w);
      b1_tgt_x <= in_tgt_x;
    end
  end

  // Second stage: add the plane base and target column.
  always_comb begin
    unique case (b1_flags.plane)
      PLANE_Y: base_sel = '0;
      PLANE_U: base_sel = base_u;
      PLANE_V: base_sel = base_v;
      default: base_sel = '0;
    endcase
    addr_sum = SUM_W'(base_sel) + SUM_W'(b1_prod) + SUM_W'(b1_tgt_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b2_ready) begin
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_ready && b1_valid) begin
      out_flags <= b1_flags;
      out_pixel <= b1_pixel;
      out_addr  <= b1_flags.write_en ? addr_sum[ADDR_BITS-1:0] : '0;
    end
  end

endmodule

[design/yuv420_window_compositor.sv]
// ----------------------------------------------------------------------------
// YUV420 window compositor
// Maps a planar YUV420 source byte stream into a window of a destination frame.
// ----------------------------------------------------------------------------
// Source bytes enter on the s_ channel in file order (Y plane, then U, then
// V), one request per byte; s_tuser marks the first byte of a frame. Each byte
// yields exactly one request on the m_ channel carrying the write enable,
// destination byte address, the byte itself, an out-of-frame flag, the plane
// on m_tuser and the last byte of the frame on m_tlast.
// Throughput is one byte per clock while m_tready stays high. A result passes
// through the queue stage, then the row-offset multiply, then the base add into
// the output register.
// A four-entry queue separates position tracking from the address pipeline;
// when the receiver stalls, the pipeline holds and s_tready drops only once
// the queue is full.
// Reset clears the plane, row and column counters, the queue and the pipeline,
// and restores the default configuration. Registers are written through
// cfg_we / cfg_index / cfg_data; frame sizes are stored clamped and aligned.
// ----------------------------------------------------------------------------
module yuv420_window_compositor
  import ywc_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF,
  parameter int ALIGN_STEP = ALIGN_STEP_DEF,
  localparam int OUT_W      = 1 + ADDR_BITS + PIXEL_W + 1,
  localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  // Source byte stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [PIXEL_W-1:0]     s_tdata,   // pixel
  input  logic                   s_tuser,   // frame_start
  // Destination write stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // write_enable, dest_address,
                                            // pixel_out, out_of_frame, zero pad
  output logic [1:0]             m_tuser,   // plane
  output logic                   m_tlast    // frame_end
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int CMP_W   = ((CNT_W > WIN_POS_W) ? CNT_W : WIN_POS_W) + 1;
  localparam int RSH     = DIM_W + 1;
  localparam int RECIP   = (1 << RSH) / ALIGN_STEP;
  localparam int ENTRY_W = FLAGS_W + PIXEL_W + 2 * CMP_W + DIM_W;

  // Clamp a size into range and floor it to the alignment step.
  function automatic logic [DIM_W-1:0] align_size(input logic [REG_W-1:0] v);
    logic [DIM_W-1:0]     c;
    logic [DIM_W+RSH-1:0] prod;
    logic [DIM_W-1:0]     q;
    logic [DIM_W-1:0]     t;
    if (v < REG_W'(ALIGN_STEP)) begin
      c = DIM_W'(ALIGN_STEP);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      c = DIM_W'(MAX_DIM);
    end else begin
      c = DIM_W'(v);
    end
    // The reciprocal estimate is at most one step low.
    prod = (DIM_W + RSH)'(c) * (DIM_W + RSH)'(RECIP);
    q    = DIM_W'(prod >> RSH);
    t    = DIM_W'(q * DIM_W'(ALIGN_STEP));
    if ((c - t) >= DIM_W'(ALIGN_STEP)) begin
      t = t + DIM_W'(ALIGN_STEP);
    end
    return t;
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0]     src_w;
  logic [DIM_W-1:0]     src_h;
  logic [DIM_W-1:0]     dst_w;
  logic [DIM_W-1:0]     dst_h;
  logic [WIN_POS_W-1:0] win_x;
  logic [WIN_POS_W-1:0] win_y;
  logic [REG_W-1:0]     win_w;
  logic [REG_W-1:0]     win_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= align_size(REG_W'(960));
      src_h <= align_size(REG_W'(720));
      dst_w <= align_size(REG_W'(1920));
      dst_h <= align_size(REG_W'(1080));
      win_x <= '0;
      win_y <= '0;
      win_w <= REG_W'(720);
      win_h <= REG_W'(576);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SRC_WIDTH:  src_w <= align_size(cfg_data);
        CFG_SRC_HEIGHT: src_h <= align_size(cfg_data);
        CFG_DST_WIDTH:  dst_w <= align_size(cfg_data);
        CFG_DST_HEIGHT: dst_h <= align_size(cfg_data);
        CFG_WIN_X:      win_x <= cfg_data[WIN_POS_W-1:0];
        CFG_WIN_Y:      win_y <= cfg_data[WIN_POS_W-1:0];
        CFG_WIN_W:      win_w <= cfg_data;
        CFG_WIN_H:      win_h <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Front: position tracking and classification.
  logic               accept;
  item_flags_t        f_flags;
  logic [CMP_W-1:0]   f_tgt_x;
  logic [CMP_W-1:0]   f_tgt_y;
  logic [DIM_W-1:0]   f_lim_w;
  logic [ENTRY_W-1:0] q_push_data;

  assign accept = s_tvalid && s_tready;

  ywc_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_tuser),
    .src_w       (src_w),
    .src_h       (src_h),
    .dst_w       (dst_w),
    .dst_h       (dst_h),
    .win_x       (win_x),
    .win_y       (win_y),
    .win_w       (win_w),
    .win_h       (win_h),
    .flags       (f_flags),
    .tgt_x       (f_tgt_x),
    .tgt_y       (f_tgt_y),
    .lim_w       (f_lim_w)
  );

  assign q_push_data = {f_flags, s_tdata, f_tgt_x, f_tgt_y, f_lim_w};

  // Queue between the front and the back.
  logic               q_pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_pop_data;
  item_flags_t        q_flags;
  logic [PIXEL_W-1:0] q_pixel;
  logic [CMP_W-1:0]   q_tgt_x;
  logic [CMP_W-1:0]   q_tgt_y;
  logic [DIM_W-1:0]   q_lim_w;

  ywc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (q_push_data),
    .push_ready (s_tready),
    .pop        (q_pop),
    .pop_data   (q_pop_data),
    .pop_valid  (q_valid)
  );

  assign {q_flags, q_pixel, q_tgt_x, q_tgt_y, q_lim_w} = q_pop_data;

  // Back: destination address pipeline.
  item_flags_t          o_flags;
  logic [PIXEL_W-1:0]   o_pixel;
  logic [ADDR_BITS-1:0] o_addr;

  ywc_back #(
    .MAX_DIM   (MAX_DIM),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .dst_w     (dst_w),
    .dst_h     (dst_h),
    .in_valid  (q_valid),
    .in_pop    (q_pop),
    .in_flags  (q_flags),
    .in_pixel  (q_pixel),
    .in_tgt_x  (q_tgt_x),
    .in_tgt_y  (q_tgt_y),
    .in_lim_w  (q_lim_w),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_flags (o_flags),
    .out_pixel (o_pixel),
    .out_addr  (o_addr)
  );

  // Result packing.
  assign m_tdata = M_TDATA_W'({o_flags.out_of_frame, o_pixel, o_addr, o_flags.write_en});
  assign m_tuser = o_flags.plane;
  assign m_tlast = o_flags.frame_end;

endmodule

[bench/tb_yuv420_window_compositor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV420 window compositor testbench
// Streams planar YUV420 source bytes into the compositor and checks every
// destination write request against an in-bench placement predictor. The run
// covers reset defaults, clamped and aligned sizes, windows past the frame
// edge, settings changed mid-frame, and well-formed and broken frames under
// several patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_yuv420_window_compositor;
  import ywc_pkg::*;

  localparam int ADDR_W     = ADDR_BITS_DEF;
  localparam int SIZE_MAX   = MAX_DIM_DEF;
  localparam int SIZE_STEP  = ALIGN_STEP_DEF;
  localparam int OUT_BITS   = 1 + ADDR_W + PIXEL_W + 1;
  localparam int TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
  localparam int PHASE_BYTES = 150;

  // Kinds of register setting applied before a phase.
  typedef enum int {
    SET_RANDOM,
    SET_MAX,
    SET_MIN
  } setting_kind_t;

  // One expected destination write request.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pix;
    logic              oof;
    plane_t            plane;
    logic              fend;
  } blit_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [PIXEL_W-1:0]     s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_BITS-1:0]  m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;

  yuv420_window_compositor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Predictor copy of the registers and the position counters.
  logic [12:0] src_w_cfg = 13'd960;
  logic [12:0] src_h_cfg = 13'd720;
  logic [12:0] dst_w_cfg = 13'd1920;
  logic [12:0] dst_h_cfg = 13'd1080;
  logic [11:0] win_x_cfg = 12'd0;
  logic [11:0] win_y_cfg = 12'd0;
  logic [12:0] win_w_cfg = 13'd720;
  logic [12:0] win_h_cfg = 13'd576;
  plane_t      cur_plane = PLANE_Y;
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;

  blit_result_t expected_writes[$];

  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int writes_seen = 0;
  int clipped_seen = 0;
  int frames_done = 0;
  int settings_applied = 0;

  // Clock: 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sink side: random backpressure at the rate of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Sizes are clamped to the legal range and floored to the alignment step.
  function automatic int unsigned fit_size(logic [12:0] v);
    int unsigned s;
    s = v;
    if (s < SIZE_STEP) s = SIZE_STEP;
    if (s > SIZE_MAX) s = SIZE_MAX;
    return s / SIZE_STEP * SIZE_STEP;
  endfunction

  // Bytes in one whole source frame under the current setting.
  function automatic int unsigned frame_bytes();
    int unsigned sw, sh;
    sw = fit_size(src_w_cfg);
    sh = fit_size(src_h_cfg);
    return sw * sh + 2 * (sw / 2) * (sh / 2);
  endfunction

  // Places one source byte: works out its destination write and advances the
  // plane, row and column counters.
  function automatic blit_result_t place_byte(logic [7:0] pix, logic first);
    blit_result_t    r;
    int unsigned     sw, sh, dw, dh, cw, ch;
    int unsigned     pw, ph, copy_w, copy_h, ox, oy, lim_w, lim_h;
    longint unsigned base, tx, ty, row_addr;
    sw = fit_size(src_w_cfg);
    sh = fit_size(src_h_cfg);
    dw = fit_size(dst_w_cfg);
    dh = fit_size(dst_h_cfg);
    cw = (win_w_cfg < sw) ? win_w_cfg : sw;
    ch = (win_h_cfg < sh) ? win_h_cfg : sh;
    if (first) begin
      cur_plane = PLANE_Y;
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_plane == PLANE_Y) begin
      pw = sw; ph = sh; copy_w = cw; copy_h = ch;
      ox = win_x_cfg; oy = win_y_cfg; lim_w = dw; lim_h = dh;
      base = 0;
    end else begin
      pw = sw / 2; ph = sh / 2; copy_w = cw / 2; copy_h = ch / 2;
      ox = win_x_cfg / 2; oy = win_y_cfg / 2; lim_w = dw / 2; lim_h = dh / 2;
      base = longint'(dw) * dh;
      if (cur_plane == PLANE_V) base = base * 5 / 4;
    end
    ty = longint'(oy) + cur_row;
    tx = longint'(ox) + cur_col;
    row_addr = base + ty * lim_w + ox;
    r = '0;
    r.pix = pix;
    r.plane = cur_plane;
    if (cur_col < copy_w && cur_row < copy_h) begin
      if (tx < lim_w && ty < lim_h) begin
        r.we = 1'b1;
        r.addr = ADDR_W'(row_addr + cur_col);
      end else begin
        r.oof = 1'b1;
      end
    end
    // Counters at or past their limit wrap, which also covers shrunk sizes.
    if (cur_col + 1 >= pw) begin
      cur_col = 0;
      if (cur_row + 1 >= ph) begin
        cur_row = 0;
        if (cur_plane == PLANE_V) begin
          cur_plane = PLANE_Y;
          r.fend = 1'b1;
        end else if (cur_plane == PLANE_Y) begin
          cur_plane = PLANE_U;
        end else begin
          cur_plane = PLANE_V;
        end
      end else begin
        cur_row++;
      end
    end else begin
      cur_col++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned want);
    if (mismatch_count < 30)
      $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
               what, results_checked, got, want);
    mismatch_count++;
  endtask

  // Predict each accepted source byte, then check each accepted write request
  // against the oldest prediction.
  always @(posedge clk) begin : check_writes
    blit_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_writes.push_back(place_byte(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected request", m_tdata, 0);
        end else begin
          want = expected_writes.pop_front();
          if (m_tdata[0] !== want.we)
            report_mismatch("write_enable", m_tdata[0], want.we);
          if (m_tdata[ADDR_W:1] !== want.addr)
            report_mismatch("dest_address", m_tdata[ADDR_W:1], want.addr);
          if (m_tdata[ADDR_W+8:ADDR_W+1] !== want.pix)
            report_mismatch("pixel_out", m_tdata[ADDR_W+8:ADDR_W+1], want.pix);
          if (m_tdata[ADDR_W+9] !== want.oof)
            report_mismatch("out_of_frame", m_tdata[ADDR_W+9], want.oof);
          if ((m_tdata >> OUT_BITS) !== '0)
            report_mismatch("tdata padding", m_tdata >> OUT_BITS, 0);
          if (m_tuser !== want.plane)
            report_mismatch("plane", m_tuser, want.plane);
          if (m_tlast !== want.fend)
            report_mismatch("frame_end", m_tlast, want.fend);
          if (want.we) writes_seen++;
          if (want.oof) clipped_seen++;
          if (want.fend) frames_done++;
        end
        results_checked++;
      end
    end
  end

  // Sends one source byte; entered and left at a falling edge.
  task automatic send_byte(logic [7:0] pix, logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Holds the source back until every predicted request has come out.
  task automatic drain_writes();
    s_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write; the caller lowers cfg_we after the last one.
  task automatic write_reg(cfg_index_t idx, logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SRC_WIDTH:  src_w_cfg = val;
      CFG_SRC_HEIGHT: src_h_cfg = val;
      CFG_DST_WIDTH:  dst_w_cfg = val;
      CFG_DST_HEIGHT: dst_h_cfg = val;
      CFG_WIN_X:      win_x_cfg = val[11:0];
      CFG_WIN_Y:      win_y_cfg = val[11:0];
      CFG_WIN_W:      win_w_cfg = val;
      CFG_WIN_H:      win_h_cfg = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [12:0] pick_dst_size();
    case ($urandom_range(0, 3))
      0: return 13'($urandom_range(0, 40));
      1: return 13'd4096;
      2: return 13'($urandom);
      default: return 13'd8191;
    endcase
  endfunction

  function automatic logic [12:0] pick_win_pos();
    case ($urandom_range(0, 3))
      0, 1: return 13'($urandom_range(0, 40));
      2: return 13'($urandom);
      default: return 13'h1FFF;
    endcase
  endfunction

  function automatic logic [12:0] pick_win_size();
    case ($urandom_range(0, 4))
      0: return 13'd0;
      1, 2: return 13'($urandom_range(0, 32));
      3: return 13'd4096;
      default: return 13'($urandom);
    endcase
  endfunction

  // Writes all eight registers once the pipeline is empty.
  task automatic apply_setting(setting_kind_t kind);
    logic [12:0] sw, sh;
    drain_writes();
    case (kind)
      SET_MAX: begin
        write_reg(CFG_SRC_WIDTH, 13'h1FFF);
        write_reg(CFG_SRC_HEIGHT, 13'h1FFF);
        write_reg(CFG_DST_WIDTH, 13'h1FFF);
        write_reg(CFG_DST_HEIGHT, 13'd4096);
        write_reg(CFG_WIN_X, 13'd4095);
        write_reg(CFG_WIN_Y, 13'd4095);
        write_reg(CFG_WIN_W, 13'h1FFF);
        write_reg(CFG_WIN_H, 13'd4096);
      end
      SET_MIN: begin
        write_reg(CFG_SRC_WIDTH, 13'd0);
        write_reg(CFG_SRC_HEIGHT, 13'd0);
        write_reg(CFG_DST_WIDTH, 13'd0);
        write_reg(CFG_DST_HEIGHT, 13'd0);
        write_reg(CFG_WIN_X, 13'd0);
        write_reg(CFG_WIN_Y, 13'd0);
        write_reg(CFG_WIN_W, 13'd0);
        write_reg(CFG_WIN_H, 13'd0);
      end
      default: begin
        // Mostly small sources so that whole frames fit into one phase.
        sw = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 13));
        sh = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 9));
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, pick_dst_size());
        write_reg(CFG_DST_HEIGHT, pick_dst_size());
        write_reg(CFG_WIN_X, pick_win_pos());
        write_reg(CFG_WIN_Y, pick_win_pos());
        write_reg(CFG_WIN_W, pick_win_size());
        write_reg(CFG_WIN_H, pick_win_size());
      end
    endcase
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_applied++;
  endtask

  // A phase of random traffic: mostly whole frames, some cut short, some
  // loose bytes with random frame starts. Midway the source waits for the
  // pipeline to empty.
  task automatic run_phase(setting_kind_t kind, int src_pct, int sink_pct);
    int          start;
    int          roll;
    int unsigned len;
    bit          drained;
    apply_setting(kind);
    send_idle_pct  = src_pct;
    sink_stall_pct = sink_pct;
    start = bytes_sent;
    drained = 1'b0;
    while (bytes_sent - start < PHASE_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) len = frame_bytes();
      else if (roll < 90) len = $urandom_range(1, frame_bytes());
      else len = $urandom_range(1, 6);
      for (int unsigned k = 0; k < len && bytes_sent - start < PHASE_BYTES; k++) begin
        if (roll < 90) send_byte(8'($urandom_range(0, 255)), k == 0);
        else send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      if (!drained && bytes_sent - start >= PHASE_BYTES / 2) begin
        drain_writes();
        drained = 1'b1;
      end
    end
    send_idle_pct  = 0;
    sink_stall_pct = 0;
  endtask

  // Default setting straight out of reset, pixel extremes included.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
  endtask

  // Sizes outside the legal range, a window in the far corner of the largest
  // destination, and a source shrunk below the live column count so that
  // the counters wrap. Runs on through the chroma planes and the frame end.
  task automatic test_clip_and_wrap();
    drain_writes();
    write_reg(CFG_SRC_WIDTH, 13'd1);
    write_reg(CFG_SRC_HEIGHT, 13'd2);
    write_reg(CFG_DST_WIDTH, 13'h1FFF);
    write_reg(CFG_DST_HEIGHT, 13'd4096);
    write_reg(CFG_WIN_X, 13'd4095);
    write_reg(CFG_WIN_Y, 13'h1FFF);
    write_reg(CFG_WIN_W, 13'h1FFF);
    write_reg(CFG_WIN_H, 13'd4096);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_applied++;
    for (int i = 0; i < 22; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_no_idle();
    run_phase(SET_MAX, 0, 0);
    run_phase(SET_RANDOM, 0, 0);
  endtask

  task automatic test_source_gaps();
    run_phase(SET_MIN, 88, 0);
    run_phase(SET_RANDOM, 88, 0);
  endtask

  task automatic test_sink_stalls();
    run_phase(SET_RANDOM, 0, 88);
    run_phase(SET_RANDOM, 0, 88);
  endtask

  task automatic test_mixed_idling();
    run_phase(SET_RANDOM, 14, 14);
    run_phase(SET_RANDOM, 14, 14);
  endtask

  // Main sequence.
  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_clip_and_wrap();
    test_no_idle();
    test_source_gaps();
    test_sink_stalls();
    test_mixed_idling();

    drain_writes();
    repeat (10) @(negedge clk);
    if (expected_writes.size() != 0)
      report_mismatch("requests never delivered", expected_writes.size(), 0);

    $display("Summary: %0d source bytes under %0d register settings, %0d requests checked.",
             bytes_sent, settings_applied, results_checked);
    $display("Summary: %0d writes, %0d clipped past the frame edge, %0d frames completed.",
             writes_seen, clipped_seen, frames_done);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: stops the run with a failure if the main sequence hangs.
  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
design/ywc_pkg.sv
design/ywc_queue.sv
design/ywc_front.sv
design/ywc_back.sv
design/yuv420_window_compositor.sv
bench/tb_yuv420_window_compositor.sv
